FILE: hw/rtl/civ_cfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CI-V command frame encoder package
// Shared item types, operation codes and frame byte constants.
// ----------------------------------------------------------------------------
package civ_cfe_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_SYNC     = 2'd0;
    localparam logic [1:0] OP_BEGIN_TX = 2'd1;
    localparam logic [1:0] OP_END_TX   = 2'd2;

    // Fixed bytes of a frame.
    localparam logic [7:0] PREAMBLE_BYTE   = 8'hFE;
    localparam logic [7:0] CONTROLLER_ADDR = 8'hE0;
    localparam logic [7:0] TERMINATOR_BYTE = 8'hFD;
    localparam logic [7:0] DEST_RESET      = 8'hA4;
    localparam logic [7:0] CMD_DATA_MODE   = 8'h1A;
    localparam logic [7:0] CMD_SET_FREQ    = 8'h05;
    localparam logic [7:0] CMD_PTT         = 8'h1C;
    localparam logic [7:0] SUB_DATA_MODE   = 8'h06;

    // Ten BCD digits cover the whole 32-bit frequency range.
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Input item.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] frequency_hz;
    } cmd_in_t;

    // Result item.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       last;
    } frame_out_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [1:0]       operation;
        logic [BCD_W-1:0] bcd;
    } cmd_work_t;

endpackage : civ_cfe_pkg
`default_nettype wire

FILE: hw/rtl/civ_cfe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CI-V encoder front end
// Accepts command items, drops unused codes and converts the frequency
// to BCD with a double-dabble unit that handles two bits per cycle.
// ----------------------------------------------------------------------------
module civ_cfe_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire civ_cfe_pkg::cmd_in_t   cmd,
    output logic                        push,
    output civ_cfe_pkg::cmd_work_t      push_data,
    input  wire logic                   q_full
);
    import civ_cfe_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'd15;

    logic             conv_reg, conv_next;
    logic             pend_reg, pend_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [1:0]       op_reg, op_next;
    logic [31:0]      bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             accept;
    logic [BCD_W-1:0] adj1, adj2;

    // Adds three to every digit above four before the next shift.
    function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (v[4*d +: 4] > 4'd4)
            begin
                r[4*d +: 4] = v[4*d +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // Handshake towards the source and towards the queue.
    assign push      = pend_reg && !q_full;
    assign cmd_stall = conv_reg || (pend_reg && q_full);
    assign accept    = cmd_valid && !cmd_stall;

    assign push_data.operation = op_reg;
    assign push_data.bcd       = bcd_reg;

    // Two double-dabble iterations per cycle.
    assign adj1 = dd_adjust(bcd_reg);
    assign adj2 = dd_adjust({adj1[BCD_W-2:0], bin_reg[31]});

    always_comb
    begin
        conv_next = conv_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;

        if (push)
        begin
            pend_next = 1'b0;
        end

        if (conv_reg)
        begin
            bcd_next = {adj2[BCD_W-2:0], bin_reg[30]};
            bin_next = {bin_reg[29:0], 2'b00};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == LAST_STEP)
            begin
                conv_next = 1'b0;
                pend_next = 1'b1;
            end
        end

        // Classify a newly accepted item.
        if (accept)
        begin
            op_next = cmd.operation;
            unique case (cmd.operation) inside
                OP_SYNC, OP_BEGIN_TX:
                begin
                    conv_next = 1'b1;
                    cnt_next  = 4'd0;
                    bin_next  = cmd.frequency_hz;
                    bcd_next  = '0;
                end
                OP_END_TX:
                begin
                    pend_next = 1'b1;
                end
                default:
                begin
                    // Unused code: the item is dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg <= 1'b0;
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            conv_reg <= conv_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule : civ_cfe_front
`default_nettype wire

FILE: hw/rtl/civ_cfe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CI-V encoder command queue
// Short first-in first-out queue that parts the front end from the back end.
// ----------------------------------------------------------------------------
module civ_cfe_queue #(
    parameter int DEPTH = civ_cfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire civ_cfe_pkg::cmd_work_t  push_data,
    output logic                         full,
    input  wire logic                    pop,
    output logic                         q_valid,
    output civ_cfe_pkg::cmd_work_t       head
);
    import civ_cfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_work_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : civ_cfe_queue
`default_nettype wire

FILE: hw/rtl/civ_cfe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CI-V encoder back end
// Walks the byte positions of the frames for one command and presents one
// byte per cycle through an output register while frame_stall is low.
// ----------------------------------------------------------------------------
module civ_cfe_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [7:0]              dest_address,
    input  wire logic                    q_valid,
    input  wire civ_cfe_pkg::cmd_work_t  head,
    output logic                         pop,
    output logic                         frame_valid,
    input  wire logic                    frame_stall,
    output civ_cfe_pkg::frame_out_t      frame
);
    import civ_cfe_pkg::*;

    // Positions in the combined stream: data-mode frame, set-frequency
    // frame, then the PTT frame.
    localparam logic [4:0] POS_FIRST    = 5'd0;
    localparam logic [4:0] POS_SYNC_END = 5'd19;
    localparam logic [4:0] POS_PTT      = 5'd20;
    localparam logic [4:0] POS_PTT_END  = 5'd27;

    logic             active_reg, active_next;
    logic [4:0]       idx_reg, idx_next;
    logic [4:0]       end_reg, end_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             ptt_on_reg, ptt_on_next;
    logic             out_valid_reg, out_valid_next;
    frame_out_t       out_reg, out_next;
    logic             advance;
    logic [7:0]       cur_byte;
    logic             cur_eof;

    // Byte at the current stream position.
    always_comb
    begin
        cur_eof = 1'b0;
        case (idx_reg) inside
            5'd0, 5'd1, 5'd9, 5'd10, 5'd20, 5'd21: cur_byte = PREAMBLE_BYTE;
            5'd2, 5'd11, 5'd22:                    cur_byte = dest_address;
            5'd3, 5'd12, 5'd23:                    cur_byte = CONTROLLER_ADDR;
            5'd4:                                  cur_byte = CMD_DATA_MODE;
            5'd5:                                  cur_byte = SUB_DATA_MODE;
            5'd6, 5'd7:                            cur_byte = 8'h01;
            5'd13:                                 cur_byte = CMD_SET_FREQ;
            5'd14:                                 cur_byte = bcd_reg[7:0];
            5'd15:                                 cur_byte = bcd_reg[15:8];
            5'd16:                                 cur_byte = bcd_reg[23:16];
            5'd17:                                 cur_byte = bcd_reg[31:24];
            5'd18:                                 cur_byte = bcd_reg[39:32];
            5'd24:                                 cur_byte = CMD_PTT;
            5'd25:                                 cur_byte = 8'h00;
            5'd26:                                 cur_byte = {7'd0, ptt_on_reg};
            5'd8, 5'd19, 5'd27:
            begin
                cur_byte = TERMINATOR_BYTE;
                cur_eof  = 1'b1;
            end
            default:                               cur_byte = 8'h00;
        endcase
    end

    assign advance     = !out_valid_reg || !frame_stall;
    assign pop         = q_valid && !active_reg;
    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

    // Sequencer and output register.
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        bcd_next       = bcd_reg;
        ptt_on_next    = ptt_on_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (pop)
        begin
            active_next = 1'b1;
            bcd_next    = head.bcd;
            ptt_on_next = (head.operation == OP_BEGIN_TX);
            unique case (head.operation)
                OP_SYNC:
                begin
                    idx_next = POS_FIRST;
                    end_next = POS_SYNC_END;
                end
                OP_BEGIN_TX:
                begin
                    idx_next = POS_FIRST;
                    end_next = POS_PTT_END;
                end
                default:
                begin
                    idx_next = POS_PTT;
                    end_next = POS_PTT_END;
                end
            endcase
        end
        else if (active_reg && advance)
        begin
            out_valid_next          = 1'b1;
            out_next.frame_byte     = cur_byte;
            out_next.end_of_frame   = cur_eof;
            out_next.last           = (idx_reg == end_reg);
            idx_next                = idx_reg + 5'd1;
            if (idx_reg == end_reg)
            begin
                active_next = 1'b0;
            end
        end

        if (advance && !(active_reg && !pop))
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        bcd_reg    <= bcd_next;
        ptt_on_reg <= ptt_on_next;
        out_reg    <= out_next;
    end

endmodule : civ_cfe_back
`default_nettype wire

FILE: hw/rtl/civ_command_frame_encoder.sv
`default_nettype none
// Latency: sync and begin-transmit items pass BCD conversion at two bits per cycle,
// then every item passes the pending flag, queue, sequencer and output register.
// Throughput: one byte per cycle while not stalled; the back end pops a command
// only when idle, and the front end stalls new items while it converts.
// Reset clears all control state and sets dest_address to A4; no clearing pass.
// ----------------------------------------------------------------------------
// CI-V command frame encoder
// Turns radio commands into the byte stream of CI-V frames, with a front end
// for classification and BCD conversion and a back end that emits the bytes.
// ----------------------------------------------------------------------------
module civ_command_frame_encoder #(
    parameter int QUEUE_DEPTH = civ_cfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [7:0]              cfg_data,
    input  wire logic                    cmd_valid,
    output logic                         cmd_stall,
    input  wire civ_cfe_pkg::cmd_in_t    cmd,
    output logic                         frame_valid,
    input  wire logic                    frame_stall,
    output civ_cfe_pkg::frame_out_t      frame
);
    import civ_cfe_pkg::*;

    logic [7:0] dest_reg;
    logic       push;
    cmd_work_t  push_data;
    logic       q_full;
    logic       q_valid;
    cmd_work_t  head;
    logic       pop;

    // Destination address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= DEST_RESET;
        end
        else if (cfg_write)
        begin
            dest_reg <= cfg_data;
        end
    end

    civ_cfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    civ_cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    civ_cfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dest_address (dest_reg),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame)
    );

endmodule : civ_command_frame_encoder
`default_nettype wire

FILE: tb/tb_civ_command_frame_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the CI-V command frame encoder
// Feeds radio commands with random gaps, stalls the byte stream at random and
// checks every frame byte against frames predicted from each accepted item,
// across several destination addresses written between phases.
// ----------------------------------------------------------------------------
module tb_civ_command_frame_encoder;

    import civ_cfe_pkg::*;

    // Operation code that the encoder ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Last payload byte of a PTT frame.
    localparam logic [7:0] PTT_ON  = 8'h01;
    localparam logic [7:0] PTT_OFF = 8'h00;

    // Cycles allowed for the encoder to settle after the last byte of a phase.
    localparam int SETTLE_CYCLES    = 60;
    localparam int IDLE_LIMIT       = 2000;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 84;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_write   = 1'b0;
    logic [7:0] cfg_data    = 8'h00;
    logic       cmd_valid   = 1'b0;
    logic       cmd_stall;
    cmd_in_t    cmd         = '0;
    logic       frame_valid;
    logic       frame_stall = 1'b0;
    frame_out_t frame;

    cmd_in_t    pending_cmds[$];
    frame_out_t expected_bytes[$];
    logic [7:0] dest_shadow = DEST_RESET;
    bit         cmd_taken   = 1'b0;
    bit         pauses_on   = 1'b1;
    int         cmd_gap     = 0;
    int         stall_left  = 0;
    int         idle_cycles = 0;
    int         mismatches  = 0;

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    civ_command_frame_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    // Pause length: mostly none or short, now and then long.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (!pauses_on || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_frame_byte(input logic [7:0] value, input logic eof);
        frame_out_t b;
        b.frame_byte   = value;
        b.end_of_frame = eof;
        b.last         = 1'b0;
        expected_bytes.push_back(b);
    endfunction

    // Appends one whole frame to the expected byte stream.
    function automatic void add_frame(input logic [7:0] command,
                                      input logic [7:0] payload [5], input int len);
        push_frame_byte(PREAMBLE_BYTE, 1'b0);
        push_frame_byte(PREAMBLE_BYTE, 1'b0);
        push_frame_byte(dest_shadow, 1'b0);
        push_frame_byte(CONTROLLER_ADDR, 1'b0);
        push_frame_byte(command, 1'b0);
        for (int i = 0; i < len; i++)
            push_frame_byte(payload[i], 1'b0);
        push_frame_byte(TERMINATOR_BYTE, 1'b1);
    endfunction

    // Works out the frames that one command produces.
    function automatic void encode_command(input cmd_in_t c);
        logic [7:0]  payload [5];
        logic [31:0] rest;
        logic [3:0]  lo;
        logic [3:0]  hi;
        frame_out_t  tail;
        if (c.operation == OP_UNUSED)
            return;
        if (c.operation == OP_SYNC || c.operation == OP_BEGIN_TX)
        begin
            payload[0] = SUB_DATA_MODE;
            payload[1] = 8'h01;
            payload[2] = 8'h01;
            add_frame(CMD_DATA_MODE, payload, 3);
            // Ten BCD digits, least significant pair first.
            rest = c.frequency_hz;
            for (int i = 0; i < 5; i++)
            begin
                lo   = 4'(rest % 32'd10);
                rest = rest / 32'd10;
                hi   = 4'(rest % 32'd10);
                rest = rest / 32'd10;
                payload[i] = {hi, lo};
            end
            add_frame(CMD_SET_FREQ, payload, 5);
        end
        if (c.operation == OP_BEGIN_TX || c.operation == OP_END_TX)
        begin
            payload[0] = 8'h00;
            payload[1] = (c.operation == OP_BEGIN_TX) ? PTT_ON : PTT_OFF;
            add_frame(CMD_PTT, payload, 2);
        end
        // The final byte of the command carries the last flag.
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
    endfunction

    function automatic void queue_cmd(input logic [1:0] op, input logic [31:0] freq);
        cmd_in_t c;
        c.operation    = op;
        c.frequency_hz = freq;
        pending_cmds.push_back(c);
    endfunction

    // Random commands; ignored ones do not count towards the total.
    function automatic void queue_random(input int count);
        int         made;
        logic [1:0] op;
        logic [31:0] freq;
        made = 0;
        while (made < count)
        begin
            op = ($urandom_range(0, 99) < 6) ? OP_UNUSED : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: freq = $urandom();
                1: freq = $urandom_range(0, 99999);
                2: freq = $urandom_range(1800000, 54000000);
                default: freq = ($urandom_range(0, 1) != 0)
                                ? 32'hFFFFFFFF - 32'($urandom_range(0, 999))
                                : 32'($urandom_range(0, 9));
            endcase
            queue_cmd(op, freq);
            if (op != OP_UNUSED)
                made++;
        end
    endfunction

    // Command driver: a new item only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && !(cmd_valid && !cmd_taken))
        begin
            if (cmd_valid)
                cmd_gap = pick_pause();
            if (cmd_gap == 0 && pending_cmds.size() != 0)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
                if (cmd_gap > 0)
                    cmd_gap--;
            end
        end
    end

    // Stall bursts on the frame byte channel.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            frame_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            frame_stall <= 1'b0;
            stall_left = pick_pause();
        end
    end

    // Monitor: predicts on each accepted command and checks each frame byte.
    always @(posedge clk)
    begin : monitor
        frame_out_t want;
        if (rst_n)
        begin
            cmd_taken = cmd_valid && !cmd_stall;
            if (cfg_write)
                dest_shadow = cfg_data;
            if (cmd_taken)
                encode_command(cmd);
            if (frame_valid && !frame_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected frame byte %02h eof %0b last %0b",
                                 $realtime, frame.frame_byte, frame.end_of_frame,
                                 frame.last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (frame.frame_byte !== want.frame_byte
                        || frame.end_of_frame !== want.end_of_frame
                        || frame.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: frame byte mismatch: expected %02h eof %0b ",
                                      "last %0b, got %02h eof %0b last %0b"},
                                     $realtime, want.frame_byte, want.end_of_frame,
                                     want.last, frame.frame_byte, frame.end_of_frame,
                                     frame.last);
                    end
                end
            end
            if (cmd_taken || (frame_valid && !frame_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Waits until every queued item has gone in and every byte has come out.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dest(input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stimulus: directed commands at the reset address, then random phases.
    initial
    begin : stimulus
        logic [7:0] dest_values [PHASES];
        dest_values[0] = 8'h00;
        dest_values[1] = 8'hFF;
        dest_values[2] = 8'($urandom());
        dest_values[3] = 8'($urandom());
        dest_values[4] = DEST_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extremes of the frequency, every operation and the unused code.
        queue_cmd(OP_SYNC, 32'd0);
        queue_cmd(OP_SYNC, 32'hFFFFFFFF);
        queue_cmd(OP_BEGIN_TX, 32'd0);
        queue_cmd(OP_BEGIN_TX, 32'hFFFFFFFF);
        queue_cmd(OP_END_TX, 32'd0);
        queue_cmd(OP_END_TX, 32'hFFFFFFFF);
        queue_cmd(OP_UNUSED, 32'd14074000);
        queue_cmd(OP_SYNC, 32'd14074000);
        queue_cmd(OP_UNUSED, 32'd0);
        queue_cmd(OP_UNUSED, 32'hFFFFFFFF);
        queue_cmd(OP_BEGIN_TX, 32'd7074000);
        queue_cmd(OP_END_TX, 32'd7074000);
        queue_cmd(OP_SYNC, 32'd1234567890);
        queue_cmd(OP_SYNC, 32'd999999999);
        queue_cmd(OP_SYNC, 32'd1000000000);
        queue_cmd(OP_BEGIN_TX, 32'h80000000);
        queue_cmd(OP_SYNC, 32'h55555555);
        queue_cmd(OP_SYNC, 32'hAAAAAAAA);
        queue_cmd(OP_SYNC, 32'd9);
        queue_cmd(OP_SYNC, 32'd10);
        queue_cmd(OP_END_TX, 32'h12345678);
        queue_cmd(OP_BEGIN_TX, 32'd99);

        // Each phase uses its own destination address; one runs without pauses.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_dest(dest_values[p]);
            pauses_on = (p != 1);
            queue_random(RANDOM_PER_PHASE);
        end

        wait_drained();
        if (expected_bytes.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("** civ_command_frame_encoder: PASSED **");
        else
            $display("** civ_command_frame_encoder: FAILED **");
        $finish;
    end

    // Watchdog on cycles in which nothing is accepted.
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("** civ_command_frame_encoder: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/civ_cfe_pkg.sv
hw/rtl/civ_cfe_front.sv
hw/rtl/civ_cfe_queue.sv
hw/rtl/civ_cfe_back.sv
hw/rtl/civ_command_frame_encoder.sv
tb/tb_civ_command_frame_encoder.sv
